[src/kdlp_pkg.sv]
// Package with the shared constants and types of the key debounce and long press core.
`timescale 1ns / 1ps
`default_nettype none

package kdlp_pkg;

   // Number of keys; keys beyond the four input bits always read as released.
   localparam int NUM_KEYS = 4;
   localparam int RAW_W    = 4;
   // Keys that can ever report an event, one lane each.
   localparam int LANES    = (NUM_KEYS < RAW_W) ? NUM_KEYS : RAW_W;
   // Two event slots per lane: debounce event, then long press.
   localparam int EV_BITS  = 2 * LANES;

   localparam int TIME_W   = 32;
   localparam int DEB_W    = 8;
   localparam int LONG_W   = 16;
   localparam int KEY_W    = 2;
   localparam int KIND_W   = 2;

   localparam logic [KIND_W-1:0] EV_DOWN  = 2'd0;
   localparam logic [KIND_W-1:0] EV_SHORT = 2'd1;
   localparam logic [KIND_W-1:0] EV_LONG  = 2'd2;
   localparam logic [KIND_W-1:0] EV_NONE  = 2'd3;

   localparam logic REQ_SCAN = 1'b0;
   localparam logic REQ_INIT = 1'b1;

   // Configuration port.
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic CSR_IDX_DEBOUNCE = 1'b0;
   localparam logic CSR_IDX_LONG     = 1'b1;
   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd20;
   localparam logic [LONG_W-1:0] LONG_RESET     = 16'd2000;

   // Scan event queue.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic              step;
      logic              init;
      logic [TIME_W-1:0] now_ms;
      logic [DEB_W-1:0]  debounce_ms;
      logic [LONG_W-1:0] long_press_ms;
   } lane_cmd_type;

   typedef struct packed {
      logic db_valid;
      logic db_short;
      logic long_valid;
   } lane_ev_type;

   typedef struct packed {
      logic [EV_BITS-1:0] mask;
      logic [LANES-1:0]   short_key;
   } scan_ev_type;

endpackage

`default_nettype wire

[src/kdlp_req_if.sv]
// Scan request channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface kdlp_req_if
   import kdlp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [TIME_W-1:0] now_ms;
   logic [RAW_W-1:0]  raw_levels;

   modport source (output valid, output req_type, output now_ms, output raw_levels,
                   input ready);
   modport sink   (input valid, input req_type, input now_ms, input raw_levels,
                   output ready);
endinterface

`default_nettype wire

[src/kdlp_rsp_if.sv]
// Key event result channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface kdlp_rsp_if
   import kdlp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KEY_W-1:0]  key_index;
   logic [KIND_W-1:0] event_kind;
   logic              last_event;

   modport source (output valid, output key_index, output event_kind, output last_event,
                   input ready);
   modport sink   (input valid, input key_index, input event_kind, input last_event,
                   output ready);
endinterface

`default_nettype wire

[src/kdlp_lane.sv]
// One key lane: debounce state, press timing and event detection.
`timescale 1ns / 1ps
`default_nettype none

module kdlp_lane
   import kdlp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lane_cmd_type cmd,
   input  wire logic         raw,
   output lane_ev_type       ev
);

   logic              last_raw_ff, last_raw_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic [TIME_W-1:0] press_time_ff, press_time_in;
   logic              long_rep_ff, long_rep_in;

   logic              raw_change;
   logic              db_fire;
   logic              lr_mid;
   logic [TIME_W-1:0] change_age;
   logic [TIME_W-1:0] press_age;
   logic              long_fire;

   always_comb begin
      raw_change = (raw != last_raw_ff);
      change_age = cmd.now_ms - change_time_ff;
      db_fire    = !raw_change && (raw != stable_ff) &&
                   (change_age >= TIME_W'(cmd.debounce_ms));
      lr_mid     = db_fire ? 1'b0 : long_rep_ff;
      // A fresh press restarts the hold timer at zero.
      press_age  = (db_fire && !raw) ? '0 : (cmd.now_ms - press_time_ff);
      long_fire  = !(db_fire ? raw : stable_ff) && !lr_mid &&
                   (press_age >= TIME_W'(cmd.long_press_ms));

      ev.db_valid   = db_fire && (!raw || !long_rep_ff);
      ev.db_short   = raw;
      ev.long_valid = long_fire;

      last_raw_in    = last_raw_ff;
      stable_in      = stable_ff;
      change_time_in = change_time_ff;
      press_time_in  = press_time_ff;
      long_rep_in    = long_rep_ff;
      if (cmd.step) begin
         if (cmd.init) begin
            last_raw_in    = raw;
            stable_in      = raw;
            change_time_in = cmd.now_ms;
            press_time_in  = cmd.now_ms;
            long_rep_in    = 1'b0;
         end else begin
            if (raw_change) begin
               last_raw_in    = raw;
               change_time_in = cmd.now_ms;
            end
            if (db_fire) begin
               stable_in = raw;
               if (!raw) begin
                  press_time_in = cmd.now_ms;
               end
            end
            long_rep_in = lr_mid || long_fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         change_time_ff <= '0;
         press_time_ff  <= '0;
         long_rep_ff    <= 1'b0;
      end else begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         press_time_ff  <= press_time_in;
         long_rep_ff    <= long_rep_in;
      end
   end

endmodule

`default_nettype wire

[src/kdlp_merge.sv]
// Merge stage: queues per-scan event masks and issues them in key order.
`timescale 1ns / 1ps
`default_nettype none

module kdlp_merge
   import kdlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire scan_ev_type push_ev,
   output logic             can_push,
   kdlp_rsp_if.source       rsp
);

   scan_ev_type        fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;

   logic [EV_BITS-1:0] cur_mask_ff, cur_mask_in;
   logic [LANES-1:0]   cur_short_ff, cur_short_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [KIND_W-1:0]  rsp_kind_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               issue;
   logic               pop;
   logic [EV_BITS-1:0] sel_onehot;
   logic [EV_BITS-1:0] rest_mask;
   logic [KEY_W-1:0]   sel_key;
   logic [KIND_W-1:0]  sel_kind;

   // Lowest set slot wins: the loop runs downward so the last match is the lowest.
   always_comb begin
      sel_onehot = '0;
      sel_key    = '0;
      sel_kind   = EV_NONE;
      for (int i = EV_BITS - 1; i >= 0; i--) begin
         if (cur_mask_ff[i]) begin
            sel_onehot    = '0;
            sel_onehot[i] = 1'b1;
            sel_key       = KEY_W'(i >> 1);
            if ((i & 1) == 1) begin
               sel_kind = EV_LONG;
            end else begin
               sel_kind = cur_short_ff[i >> 1] ? EV_SHORT : EV_DOWN;
            end
         end
      end
   end

   always_comb begin
      can_push     = (count_ff != FIFO_CW'(FIFO_DEPTH));
      out_free     = !rsp_valid_ff || rsp.ready;
      issue        = (cur_mask_ff != '0) && out_free;
      rest_mask    = cur_mask_ff & ~sel_onehot;
      cur_mask_in  = issue ? rest_mask : cur_mask_ff;
      cur_short_in = cur_short_ff;
      pop          = (count_ff != '0) && (cur_mask_in == '0);
      if (pop) begin
         cur_mask_in  = fifo_mem[rd_ptr_ff].mask;
         cur_short_in = fifo_mem[rd_ptr_ff].short_key;
      end
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in    = (push && can_push) ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      count_in     = count_ff + FIFO_CW'(push && can_push) - FIFO_CW'(pop);
      rsp_valid_in = issue ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (push && can_push) begin
         fifo_mem[wr_ptr_ff] <= push_ev;
      end
      if (issue) begin
         rsp_key_ff  <= sel_key;
         rsp_kind_ff <= sel_kind;
         rsp_last_ff <= (rest_mask == '0);
      end
      cur_short_ff <= cur_short_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         cur_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         cur_mask_ff  <= cur_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.key_index  = rsp_key_ff;
   assign rsp.event_kind = rsp_kind_ff;
   assign rsp.last_event = rsp_last_ff;

endmodule

`default_nettype wire

[src/key_debounce_long_press_core.sv]
// Top level of the key debounce and long press core.
//
//   Channel  Direction  Beat contents                        Accepted when
//   req_ch   in         req_type, now_ms, raw_levels         valid && ready
//   rsp_ch   out        key_index, event_kind, last_event    valid && ready
//   csr_*    in/out     debounce_ms (0x0), long_press_ms (0x4)  psel&&penable&&pwrite
//
// On an accepted request beat every key lane updates at the accepting edge
// and a scan with events enters a four-entry scan queue. Its first result beat
// moves from the queue into the current-mask register and then into the output
// register; beats then leave one per cycle while the result side takes them.
// Requests are refused only while the queue is full, which happens when scans with
// many events arrive faster than they drain or when the result side stalls. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_long_press_core
   import kdlp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   kdlp_req_if.sink               req_ch,
   kdlp_rsp_if.source             rsp_ch,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [DEB_W-1:0]  debounce_ff, debounce_in;
   logic [LONG_W-1:0] long_press_ff, long_press_in;
   logic              csr_write;

   lane_cmd_type      lane_cmd;
   lane_ev_type       lane_ev [LANES];
   scan_ev_type       scan_ev;
   logic              accept;
   logic              can_push;
   logic              push;

   // Register file. The word address is taken from bit 2, lower bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_IDX_DEBOUNCE: debounce_in   = csr_pwdata[DEB_W-1:0];
            CSR_IDX_LONG:     long_press_in = csr_pwdata[LONG_W-1:0];
            default:          debounce_in   = debounce_ff;
         endcase
      end
      unique case (csr_paddr[2])
         CSR_IDX_DEBOUNCE: csr_prdata = DATA_W'(debounce_ff);
         CSR_IDX_LONG:     csr_prdata = DATA_W'(long_press_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_RESET;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
      end
   end

   // Requests are held off only when the scan queue is full.
   assign req_ch.ready = can_push;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      lane_cmd.step          = accept;
      lane_cmd.init          = (req_ch.req_type == REQ_INIT);
      lane_cmd.now_ms        = req_ch.now_ms;
      lane_cmd.debounce_ms   = debounce_ff;
      lane_cmd.long_press_ms = long_press_ff;
   end

   // Keys past the input bits never change level, so only keys with an input
   // bit get a lane; the others would hold their reset state forever.
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      kdlp_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (lane_cmd),
         .raw   (req_ch.raw_levels[k]),
         .ev    (lane_ev[k])
      );
   end

   // Slot 2k holds key k's debounce event and slot 2k+1 its long press, which
   // gives the merge stage key order with the debounce event first.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         scan_ev.mask[2*k]     = lane_ev[k].db_valid;
         scan_ev.mask[2*k + 1] = lane_ev[k].long_valid;
         scan_ev.short_key[k]  = lane_ev[k].db_short;
      end
   end

   // Initialize beats and scans without events never enter the queue.
   assign push = accept && (req_ch.req_type == REQ_SCAN) && (scan_ev.mask != '0);

   kdlp_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ev  (scan_ev),
      .can_push (can_push),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

[src/kdlp_checker.sv]
// Port-level assertions for the key debounce and long press core, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module kdlp_checker
   import kdlp_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic              csr_psel,
   input wire logic              csr_pwrite,
   input wire logic [ADDR_W-1:0] csr_paddr,
   input wire logic [DATA_W-1:0] csr_prdata
);

   // A result beat that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Reset empties the output register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only the three defined event kinds are ever issued.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != EV_NONE))
      else $error("undefined event kind issued");

   // The debounce register reads back with its upper bits clear.
   a_deb_read: assert property (@(posedge clock) disable iff (reset)
      csr_psel && !csr_pwrite && (csr_paddr[2] == CSR_IDX_DEBOUNCE)
         |-> (csr_prdata[DATA_W-1:DEB_W] == '0))
      else $error("debounce register read back wider than its field");

endmodule

bind key_debounce_long_press_core kdlp_checker u_kdlp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.event_kind),
   .csr_psel   (csr_psel),
   .csr_pwrite (csr_pwrite),
   .csr_paddr  (csr_paddr),
   .csr_prdata (csr_prdata)
);

`default_nettype wire
